// ===== design/midi_message_parser_fifo_assert.svh =====
// Assertion macros shared by the MIDI message parser FIFO RTL.
`ifndef MIDI_MESSAGE_PARSER_FIFO_ASSERT_SVH
`define MIDI_MESSAGE_PARSER_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mmpf same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mmpf next-cycle check failed");

`endif

// ===== design/mmpf_pkg.sv =====
// Types and constants of the MIDI message parser FIFO.
`default_nettype none

package mmpf_pkg;

  // Item kinds on the input channel
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Status nibbles and reported status codes
  localparam logic [3:0] NIB_CC    = 4'hB;
  localparam logic [3:0] NIB_PC    = 4'hC;
  localparam logic [7:0] STATUS_CC = 8'hB0;
  localparam logic [7:0] STATUS_PC = 8'hC0;

  // Data byte counts per message type
  localparam logic [1:0] COUNT_CC = 2'd2;
  localparam logic [1:0] COUNT_PC = 2'd1;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] status_code;
    logic [3:0] midi_channel;
    logic [1:0] byte_count;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } out_item_t;

  // One stored message
  typedef struct packed {
    logic       is_pc;
    logic [3:0] chan;
    logic [6:0] d0;
    logic [6:0] d1;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Pending message type of the parser
  typedef enum logic [2:0] {
    PEND_NONE = 3'b001,
    PEND_CC   = 3'b010,
    PEND_PC   = 3'b100
  } pend_t;

endpackage

`default_nettype wire

// ===== design/mmpf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mmpf_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, hold the data otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/midi_message_parser_fifo.sv =====
// Top level: MIDI byte parser feeding a message FIFO with read-request pops.
//
// Input channel (in_valid / in_stall / in_item): each item is either a
// received MIDI byte (kind 0) or a read request (kind 1). Control Change and
// Program Change messages are assembled from status and data bytes and pushed
// into a FIFO of DEPTH entries; a message that finds the FIFO full is dropped.
// Bytes produce no result item. Each read request produces exactly one result
// item on the output channel (out_valid / out_stall / out_item): the oldest
// message with found set, or found clear and all fields zero when empty.
// A read request accepted on the input loads the RAM read register and the
// read stage, then the output register; the output register waits while the
// output is stalled. Throughput: one item per cycle while the output
// is not stalled.
// When out_stall holds the output register, the RAM read stage holds too and
// in_stall rises once that stage is occupied; nothing is lost or repeated.
// Reset empties the FIFO and clears the pending message; the message store
// itself is not cleared and needs no clearing pass.
`default_nettype none

module midi_message_parser_fifo #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mmpf_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mmpf_pkg::out_item_t      out_item
);

  import mmpf_pkg::*;

  `include "midi_message_parser_fifo_assert.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // FIFO control
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Parser state
  pend_t      pend_r, pend_nxt;
  logic [3:0] pchan_r, pchan_nxt;
  logic [6:0] pfirst_r, pfirst_nxt;
  logic       brx_r, brx_nxt;

  // Read stage and output register
  logic      s1_valid_r, s1_valid_nxt;
  logic      s1_found_r, s1_found_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic   in_acc;
  logic   out_free;
  logic   push;
  logic   push_ok;
  logic   pop_ok;
  entry_t wr_entry;
  entry_t rd_entry;
  logic [ENTRY_W-1:0] rd_bits;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Parse one byte item
  always_comb begin
    pend_nxt   = pend_r;
    pchan_nxt  = pchan_r;
    pfirst_nxt = pfirst_r;
    brx_nxt    = brx_r;
    push       = 1'b0;
    wr_entry   = '{is_pc: 1'b0, chan: pchan_r, d0: pfirst_r, d1: in_item.rx_byte[6:0]};
    if (in_acc && in_item.kind == KIND_BYTE) begin
      if (in_item.rx_byte[7]) begin
        // status byte: start a new message or abandon the pending one
        pchan_nxt  = in_item.rx_byte[3:0];
        pfirst_nxt = 7'd0;
        brx_nxt    = 1'b0;
        if (in_item.rx_byte[7:4] == NIB_CC) begin
          pend_nxt = PEND_CC;
        end else if (in_item.rx_byte[7:4] == NIB_PC) begin
          pend_nxt = PEND_PC;
        end else begin
          pend_nxt = PEND_NONE;
        end
      end else begin
        unique case (pend_r)
          PEND_PC: begin
            pfirst_nxt = in_item.rx_byte[6:0];
            push       = 1'b1;
            wr_entry   = '{is_pc: 1'b1, chan: pchan_r, d0: in_item.rx_byte[6:0], d1: 7'd0};
            pend_nxt   = PEND_NONE;
            brx_nxt    = 1'b0;
          end
          PEND_CC: begin
            if (!brx_r) begin
              pfirst_nxt = in_item.rx_byte[6:0];
              brx_nxt    = 1'b1;
            end else begin
              push     = 1'b1;
              pend_nxt = PEND_NONE;
              brx_nxt  = 1'b0;
            end
          end
          PEND_NONE: begin
            // drop stray data byte
          end
          default: begin
            pend_nxt = PEND_NONE;
          end
        endcase
      end
    end
  end

  // Advance FIFO pointers and fill count
  assign push_ok = push && (cnt_r < FULL_CNT);
  assign pop_ok  = in_acc && (in_item.kind == KIND_READ) && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_ADDR) ? '0 : wr_ptr_r + 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_ADDR) ? '0 : rd_ptr_r + 1'b1;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  // Message store
  mmpf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (push_ok),
    .wr_addr(wr_ptr_r),
    .wr_data(wr_entry),
    .rd_en  (pop_ok),
    .rd_addr(rd_ptr_r),
    .rd_data(rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);

  // Move read requests through the read stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_found_nxt = s1_found_r;
    if (in_acc) begin
      s1_valid_nxt = (in_item.kind == KIND_READ);
      s1_found_nxt = pop_ok;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Format the result item
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
      out_item_nxt  = '0;
      if (s1_found_r) begin
        out_item_nxt.found        = 1'b1;
        out_item_nxt.status_code  = rd_entry.is_pc ? STATUS_PC : STATUS_CC;
        out_item_nxt.midi_channel = rd_entry.chan;
        out_item_nxt.byte_count   = rd_entry.is_pc ? COUNT_PC : COUNT_CC;
        out_item_nxt.first_data   = rd_entry.d0;
        out_item_nxt.second_data  = rd_entry.is_pc ? 7'd0 : rd_entry.d1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      pend_r      <= PEND_NONE;
      pchan_r     <= '0;
      pfirst_r    <= '0;
      brx_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      pchan_r     <= pchan_nxt;
      pfirst_r    <= pfirst_nxt;
      brx_r       <= brx_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_found_r <= s1_found_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `MMPF_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= FULL_CNT)
  `MMPF_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, cnt_r == '0, rd_ptr_r == wr_ptr_r)
  `MMPF_ASSERT_NEXT(a_s1_hold, clk, rst_n,
                    s1_valid_r && s1_found_r && !out_free,
                    s1_valid_r && $stable(rd_bits))
  `MMPF_ASSERT_NEXT(a_pop_count, clk, rst_n, pop_ok, cnt_r == $past(cnt_r) - 1'b1)
  `MMPF_ASSERT_IMPL(a_found_code, clk, rst_n, out_valid_r && out_item_r.found,
                    out_item_r.status_code == STATUS_CC ||
                    out_item_r.status_code == STATUS_PC)

endmodule

`default_nettype wire
